// ===== hdl/ecgws_pkg.sv =====
// ----------------------------------------------------------------------------
// ECG waveform synthesiser package
// Shared widths, register indexes, heartbeat segment constants and the
// sine table generator used at elaboration.
// ----------------------------------------------------------------------------
package ecgws_pkg;

    localparam int NOISE_W  = 16;
    localparam int CODE_W   = 16;
    localparam int STEP_W   = 20;
    localparam int AMP_W    = 12;
    localparam int SINE_W   = 15;
    localparam int COEF_W   = 16;
    localparam int LEN_W    = 7;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = STEP_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ECG_AMPLITUDE = 1'b1;

    localparam logic [STEP_W-1:0] TIME_STEP_RESET     = 20'd65536;
    localparam logic [AMP_W-1:0]  ECG_AMPLITUDE_RESET = 12'd1000;

    localparam int TIME_INT_W = 10;
    localparam int WRAP_MS    = 840;

    localparam int P_START_MS = 0;
    localparam int P_LEN_MS   = 80;
    localparam int Q_START_MS = 100;
    localparam int Q_LEN_MS   = 20;
    localparam int R_START_MS = 120;
    localparam int R_LEN_MS   = 60;
    localparam int S_START_MS = 180;
    localparam int S_LEN_MS   = 80;
    localparam int T_START_MS = 340;
    localparam int T_LEN_MS   = 60;

    localparam int COEF_P = 1311;
    localparam int COEF_Q = 8192;
    localparam int COEF_R = 32768;
    localparam int COEF_S = 3932;
    localparam int COEF_T = 1966;

    localparam int MUL_A_W     = COEF_W;
    localparam int MUL_B_W     = SINE_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int MAG_W       = MUL_A_W;
    localparam int ROUND_SHIFT = 15;
    localparam int N96_W       = NOISE_W + 7;
    localparam int WORK_W      = 32;
    localparam int SCALED_W    = WORK_W + 6;
    localparam int QUO_W       = SCALED_W - ROUND_SHIFT;

    localparam int CODE_DIVISOR = 39;
    localparam int ROUND_BIAS   = 39 * 16384;
    localparam int CODE_OFFSET  = 32768;
    localparam int CODE_MAX     = 65535;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;

    // sin(pi * x / 2^bits) in Q15 for a folded phase x, evaluated as a Taylor
    // series in Q30 with truncating steps.
    function automatic logic [SINE_W-1:0] sine_q15(input int unsigned x,
                                                   input int unsigned bits);
        logic [63:0] full;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] p;
        logic [63:0] s;
        full  = 64'd1 << bits;
        theta = (64'(x) * PI_Q30 + (full >> 1)) >> bits;
        t2    = (theta * theta + (Q30_ONE >> 1)) >> 30;
        p     = Q30_ONE - t2 / 64'd110;
        p     = Q30_ONE - ((t2 * p) >> 30) / 64'd72;
        p     = Q30_ONE - ((t2 * p) >> 30) / 64'd42;
        p     = Q30_ONE - ((t2 * p) >> 30) / 64'd20;
        p     = Q30_ONE - ((t2 * p) >> 30) / 64'd6;
        s     = (theta * p) >> 30;
        s     = (s + 64'd16384) >> 15;
        return (s > 64'd32767) ? SINE_W'(32767) : s[SINE_W-1:0];
    endfunction

endpackage

// ===== hdl/ecgws_sine_rom.sv =====
// ----------------------------------------------------------------------------
// ECG synthesiser sine ROM
// Half-wave sine table in Q15 with quarter-wave folding and a registered read.
// ----------------------------------------------------------------------------
module ecgws_sine_rom
    import ecgws_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  logic                  aclk,
    input  logic [TABLE_BITS-1:0] phase,
    output logic [SINE_W-1:0]     sine
);

    localparam int HALF  = 1 << (TABLE_BITS - 1);
    localparam int DEPTH = HALF + 1;

    logic [SINE_W-1:0]     rom_table [DEPTH];
    logic [TABLE_BITS-1:0] fold_addr;
    logic [SINE_W-1:0]     sine_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_rom
        assign rom_table[i] = sine_q15(i, TABLE_BITS);
    end

    always_comb begin
        if (phase > TABLE_BITS'(HALF)) begin
            fold_addr = TABLE_BITS'(0) - phase;
        end else begin
            fold_addr = phase;
        end
    end

    always_ff @(posedge aclk) begin
        sine_reg <= rom_table[fold_addr];
    end

    assign sine = sine_reg;

endmodule

// ===== hdl/ecgws_serial_mul.sv =====
// ----------------------------------------------------------------------------
// ECG synthesiser serial multiplier
// Unsigned shift-and-add multiplier that retires one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module ecgws_serial_mul
    import ecgws_pkg::*;
#(
    parameter int A_W = 16,
    parameter int B_W = 15
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [A_W-1:0]     multiplicand,
    input  logic [B_W-1:0]     multiplier,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg, acc_next;
    logic [A_W-1:0]   mcand_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [A_W:0]     part_sum;

    always_comb begin
        part_sum  = {1'b0, acc_reg[P_W-1:B_W]} + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = {A_W'(0), multiplier};
            cnt_next  = CNT_W'(B_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = {part_sum, acc_reg[B_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (start) begin
            mcand_reg <= multiplicand;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== hdl/ecgws_serial_div.sv =====
// ----------------------------------------------------------------------------
// ECG synthesiser serial divider
// Unsigned restoring divider that produces one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ecgws_serial_div
    import ecgws_pkg::*;
#(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  fits;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_sh - {1'b0, divisor_reg};
        fits      = rem_sh >= {1'b0, divisor_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            divisor_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/ecg_waveform_synth_top.sv =====
// ----------------------------------------------------------------------------
// ECG waveform synthesiser
// Builds one amplifier code per noise sample from a half-sine heartbeat
// template, scaled amplitude and Gaussian noise.
// ----------------------------------------------------------------------------
// Each input transfer carries one standard-normal noise sample and yields one
// 16-bit amplifier code on the output channel, in order. Items are processed
// one at a time: after an input transfer the block is ready again only once
// the code is presented, and it holds the code back while the previous result
// has not been taken. Each item uses one shared bit-serial divider, run twice
// (the template phase and the conversion to code, 23 steps each), and one
// shared shift-and-add multiplier, run twice (segment coefficient and
// amplitude, 15 steps each). The finished code sits in an output register,
// so the next sample is taken while the previous code still waits. Elapsed
// time advances by time_step at each input transfer and wraps once it passes
// 840 ms. Registers are written through cfg_wr_en, cfg_index and cfg_wdata,
// and must only be written while the block is idle.
module ecg_waveform_synth_top
    import ecgws_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int TIME_FRAC_BITS  = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [NOISE_W-1:0] s_gaussian_noise,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CODE_W-1:0]       m_adc_code
);

    localparam int TIME_W  = TIME_INT_W + TIME_FRAC_BITS;
    localparam int SUM_W   = ((TIME_W > STEP_W) ? TIME_W : STEP_W) + 1;
    localparam int PHASE_W = SINE_TABLE_BITS + LEN_W;
    localparam int DIV_W   = (PHASE_W > QUO_W) ? PHASE_W : QUO_W;

    localparam logic [TIME_W-1:0] P_HI = TIME_W'(P_START_MS + P_LEN_MS) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] Q_LO = TIME_W'(Q_START_MS) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] Q_HI = TIME_W'(Q_START_MS + Q_LEN_MS) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] R_LO = TIME_W'(R_START_MS) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] R_HI = TIME_W'(R_START_MS + R_LEN_MS) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] S_LO = TIME_W'(S_START_MS) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] S_HI = TIME_W'(S_START_MS + S_LEN_MS) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] T_LO = TIME_W'(T_START_MS) << TIME_FRAC_BITS;
    localparam logic [TIME_W-1:0] T_HI = TIME_W'(T_START_MS + T_LEN_MS) << TIME_FRAC_BITS;
    localparam logic [SUM_W-1:0]  WRAP_LIM = SUM_W'(WRAP_MS) << TIME_FRAC_BITS;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PHASE = 10'b0000000010,
        ST_ROM   = 10'b0000000100,
        ST_COEF  = 10'b0000001000,
        ST_AMP   = 10'b0000010000,
        ST_MIX   = 10'b0000100000,
        ST_ABS   = 10'b0001000000,
        ST_ROUND = 10'b0010000000,
        ST_DIV   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         time_step_reg;
    logic [AMP_W-1:0]          amp_reg;
    logic [TIME_W-1:0]         elapsed_reg, elapsed_next;
    logic [SUM_W-1:0]          elapsed_sum;

    logic [TIME_W-1:0]         seg_lo;
    logic [LEN_W-1:0]          seg_len;
    logic [COEF_W-1:0]         seg_coef;
    logic                      seg_neg;
    logic [TIME_W-1:0]         seg_d;
    logic [PHASE_W-1:0]        phase_num;

    logic signed [N96_W-1:0]   noise_ext;
    logic signed [N96_W-1:0]   n96;
    logic signed [N96_W-1:0]   n96_reg;
    logic signed [WORK_W-1:0]  n96_ext;
    logic [COEF_W-1:0]         coef_reg;
    logic                      neg_reg;
    logic signed [WORK_W-1:0]  wk_reg, wk_next;
    logic                      sign_reg, sign_next;
    logic [SCALED_W-1:0]       scaled_mag;
    logic [SCALED_W-1:0]       round_val;

    logic                      in_xfer;
    logic                      load_out;
    logic                      m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]         m_adc_code_reg;
    logic [CODE_W-1:0]         code_val;
    logic [QUO_W-1:0]          code_q;

    logic                      mul_start;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_product;
    logic [MAG_W-1:0]          tmpl_mag;

    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [LEN_W-1:0]          div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_quotient;

    logic [SINE_W-1:0]         sine;

    ecgws_sine_rom #(
        .TABLE_BITS(SINE_TABLE_BITS)
    ) u_rom (
        .aclk  (aclk),
        .phase (div_quotient[SINE_TABLE_BITS-1:0]),
        .sine  (sine)
    );

    ecgws_serial_mul #(
        .A_W(MUL_A_W),
        .B_W(MUL_B_W)
    ) u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (mul_start),
        .multiplicand (mul_a),
        .multiplier   (mul_b),
        .done         (mul_done),
        .product      (mul_product)
    );

    ecgws_serial_div #(
        .DIVIDEND_W(DIV_W),
        .DIVISOR_W (LEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;

    // Segment lookup on the current time; outside every segment the
    // coefficient is zero, so the template comes out as zero.
    always_comb begin
        seg_lo   = '0;
        seg_len  = LEN_W'(P_LEN_MS);
        seg_coef = '0;
        seg_neg  = 1'b0;
        if (elapsed_reg < P_HI) begin
            seg_coef = COEF_W'(COEF_P);
        end else if (elapsed_reg > Q_LO && elapsed_reg < Q_HI) begin
            seg_lo   = Q_LO;
            seg_len  = LEN_W'(Q_LEN_MS);
            seg_coef = COEF_W'(COEF_Q);
            seg_neg  = 1'b1;
        end else if (elapsed_reg > R_LO && elapsed_reg < R_HI) begin
            seg_lo   = R_LO;
            seg_len  = LEN_W'(R_LEN_MS);
            seg_coef = COEF_W'(COEF_R);
        end else if (elapsed_reg > S_LO && elapsed_reg < S_HI) begin
            seg_lo   = S_LO;
            seg_len  = LEN_W'(S_LEN_MS);
            seg_coef = COEF_W'(COEF_S);
            seg_neg  = 1'b1;
        end else if (elapsed_reg > T_LO && elapsed_reg < T_HI) begin
            seg_lo   = T_LO;
            seg_len  = LEN_W'(T_LEN_MS);
            seg_coef = COEF_W'(COEF_T);
        end
    end

    assign seg_d     = elapsed_reg - seg_lo;
    assign phase_num = PHASE_W'({seg_d, {SINE_TABLE_BITS{1'b0}}} >> TIME_FRAC_BITS);

    assign elapsed_sum  = SUM_W'(elapsed_reg) + SUM_W'(time_step_reg);
    assign elapsed_next = (elapsed_sum > WRAP_LIM) ? '0 : TIME_W'(elapsed_sum);

    assign noise_ext = N96_W'(s_gaussian_noise);
    assign n96       = (noise_ext <<< 6) + (noise_ext <<< 5);
    assign n96_ext   = WORK_W'(n96_reg);

    assign tmpl_mag = MAG_W'(mul_product[PROD_W-1:ROUND_SHIFT])
                    + MAG_W'(mul_product[ROUND_SHIFT-1]);

    assign scaled_mag = SCALED_W'($unsigned(wk_reg));
    assign round_val  = (scaled_mag << 5) + (scaled_mag << 3) + SCALED_W'(ROUND_BIAS);

    assign code_q = div_quotient[QUO_W-1:0];

    always_comb begin
        if (sign_reg) begin
            if (code_q >= QUO_W'(CODE_OFFSET)) begin
                code_val = '0;
            end else begin
                code_val = CODE_W'(QUO_W'(CODE_OFFSET) - code_q);
            end
        end else begin
            if (code_q >= QUO_W'(CODE_OFFSET)) begin
                code_val = CODE_W'(CODE_MAX);
            end else begin
                code_val = CODE_W'(QUO_W'(CODE_OFFSET) + code_q);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        mul_start    = 1'b0;
        mul_a        = coef_reg;
        mul_b        = sine;
        div_start    = 1'b0;
        div_dividend = DIV_W'(phase_num);
        div_divisor  = seg_len;
        wk_next      = wk_reg;
        sign_next    = sign_reg;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    div_start  = 1'b1;
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE: begin
                if (div_done) begin
                    state_next = ST_ROM;
                end
            end
            ST_ROM: begin
                mul_start  = 1'b1;
                state_next = ST_COEF;
            end
            ST_COEF: begin
                if (mul_done) begin
                    mul_a      = tmpl_mag;
                    mul_b      = MUL_B_W'(amp_reg);
                    mul_start  = 1'b1;
                    state_next = ST_AMP;
                end
            end
            ST_AMP: begin
                if (mul_done) begin
                    wk_next    = WORK_W'(mul_product) + (WORK_W'(mul_product) << 2);
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                wk_next    = neg_reg ? (n96_ext - wk_reg) : (n96_ext + wk_reg);
                state_next = ST_ABS;
            end
            ST_ABS: begin
                sign_next  = wk_reg[WORK_W-1];
                wk_next    = wk_reg[WORK_W-1] ? -wk_reg : wk_reg;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(round_val >> ROUND_SHIFT);
                div_divisor  = LEN_W'(CODE_DIVISOR);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (in_xfer) begin
                elapsed_reg <= elapsed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TIME_STEP_RESET;
            amp_reg       <= ECG_AMPLITUDE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TIME_STEP: begin
                    time_step_reg <= cfg_wdata[STEP_W-1:0];
                end
                CFG_ECG_AMPLITUDE: begin
                    amp_reg <= cfg_wdata[AMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        wk_reg   <= wk_next;
        sign_reg <= sign_next;
        if (in_xfer) begin
            coef_reg <= seg_coef;
            neg_reg  <= seg_neg;
            n96_reg  <= n96;
        end
        if (load_out) begin
            m_adc_code_reg <= code_val;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_adc_code = m_adc_code_reg;

endmodule

// ===== hdl/ecgws_checker.sv =====
// ----------------------------------------------------------------------------
// ECG synthesiser port checker
// Concurrent assertions on the ports of the top level, attached by bind.
// ----------------------------------------------------------------------------
module ecgws_checker
    import ecgws_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CODE_W-1:0] m_adc_code
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_adc_code))
        else $error("Result changed or vanished before its transfer.");

    a_busy_after_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("Input ready again too soon after a transfer.");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid) ##1 !$rose(m_valid))
        else $error("Result appeared too soon after an input transfer.");

    a_result_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("New result without the input side becoming ready.");

endmodule

bind ecg_waveform_synth_top ecgws_checker u_checker (.*);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// ECG waveform synthesiser testbench
// Drives noise samples through the valid/ready input, predicts every amplifier
// code from the heartbeat template and register settings, and compares each
// output transfer with the oldest predicted code, under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ecgws_pkg::*;

    localparam longint MS_Q16      = 65536;
    localparam longint WRAP_Q16    = 840 * MS_Q16;
    localparam int     PHASE_BITS  = 10;
    localparam longint CODE_DEN    = 39 * 32768;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned PI_RAD_Q30 = 64'd3373259426;
    localparam int     CYCLE_LIMIT = 1000000;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index = CFG_TIME_STEP;
    logic [CFG_DATA_W-1:0]       cfg_wdata = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic signed [NOISE_W-1:0]   s_gaussian_noise = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [CODE_W-1:0]           m_adc_code;

    longint step_q16 = 65536;
    longint amplitude_uv = 1000;
    longint elapsed_q16 = 0;

    logic [CODE_W-1:0] expected_codes[$];
    logic [CODE_W-1:0] oldest_code;
    int mismatches = 0;
    int noise_sent = 0;
    int cycle_count = 0;
    int hold_request = 0;
    int hold_left = 0;
    bit no_gaps = 1'b0;

    ecg_waveform_synth_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_gaussian_noise (s_gaussian_noise),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_adc_code       (m_adc_code)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[ecg_waveform_synth_top] ERROR");
            $finish;
        end
    end

    function automatic longint sine_q15_entry(input longint phase);
        longint unsigned x;
        longint unsigned theta;
        longint unsigned theta_sq;
        longint unsigned poly;
        longint unsigned s;
        x = longint'(phase) & ((64'd1 << PHASE_BITS) - 1);
        if (x > (64'd1 << (PHASE_BITS - 1)))
            x = (64'd1 << PHASE_BITS) - x;
        theta = (x * PI_RAD_Q30 + (64'd1 << (PHASE_BITS - 1))) >> PHASE_BITS;
        theta_sq = (theta * theta + (ONE_Q30 >> 1)) >> 30;
        poly = ONE_Q30;
        for (int n = 5; n >= 1; n--) begin
            poly = ONE_Q30 - ((theta_sq * poly) >> 30) / longint'(2 * n * (2 * n + 1));
        end
        s = (((theta * poly) >> 30) + 64'd16384) >> 15;
        return (s > 64'd32767) ? 32767 : longint'(s);
    endfunction

    function automatic longint half_sine_segment(input longint t, input longint start_ms,
                                                 input longint len_ms, input longint coef);
        longint phase;
        phase = ((t - start_ms * MS_Q16) << PHASE_BITS) / (len_ms * MS_Q16);
        return (coef * sine_q15_entry(phase) + 16384) >>> 15;
    endfunction

    function automatic longint heartbeat_template(input longint t);
        if (t < 80 * MS_Q16)
            return half_sine_segment(t, 0, 80, 1311);
        if (t > 100 * MS_Q16 && t < 120 * MS_Q16)
            return -half_sine_segment(t, 100, 20, 8192);
        if (t > 120 * MS_Q16 && t < 180 * MS_Q16)
            return half_sine_segment(t, 120, 60, 32768);
        if (t > 180 * MS_Q16 && t < 260 * MS_Q16)
            return -half_sine_segment(t, 180, 80, 3932);
        if (t > 340 * MS_Q16 && t < 400 * MS_Q16)
            return half_sine_segment(t, 340, 60, 1966);
        return 0;
    endfunction

    function automatic logic [CODE_W-1:0] amplifier_code(input logic signed [NOISE_W-1:0] noise);
        longint scaled;
        longint mag;
        longint q;
        longint code;
        scaled = (5 * heartbeat_template(elapsed_q16) * amplitude_uv
                  + 96 * longint'(noise)) * 40;
        mag = (scaled < 0) ? -scaled : scaled;
        q = (2 * mag + CODE_DEN) / (2 * CODE_DEN);
        code = ((scaled < 0) ? -q : q) + 32768;
        if (code < 0)
            code = 0;
        else if (code > 65535)
            code = 65535;
        return code[CODE_W-1:0];
    endfunction

    function automatic logic signed [NOISE_W-1:0] random_noise();
        case ($urandom_range(9))
            0: begin
                return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            1, 2: begin
                return NOISE_W'($urandom_range(8192) - 4096);
            end
            default: begin
                return NOISE_W'($urandom);
            end
        endcase
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d at cycle %0d: %s", mismatches, cycle_count, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_codes.size() == 0) begin
                log_failure($sformatf("adc_code %0d with nothing outstanding", m_adc_code));
            end else begin
                oldest_code = expected_codes.pop_front();
                if (m_adc_code !== oldest_code)
                    log_failure($sformatf("adc_code expected %0d, actual %0d",
                                          oldest_code, m_adc_code));
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_gaps || ($urandom_range(99) >= 8);
        end
    end

    task automatic send_noise(input logic signed [NOISE_W-1:0] noise);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_gaussian_noise <= noise;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_codes.push_back(amplifier_code(noise));
        elapsed_q16 += step_q16;
        if (elapsed_q16 > WRAP_Q16)
            elapsed_q16 = 0;
        noise_sent++;
    endtask

    task automatic drain_codes();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        drain_codes();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        if (index == CFG_TIME_STEP)
            step_q16 = longint'(data);
        else
            amplitude_uv = longint'(data[AMP_W-1:0]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_noise_extremes();
        send_noise(16'sh8000);
        send_noise(16'sh7FFF);
        send_noise(16'sh0000);
        send_noise(-16'sd1);
        send_noise(16'sd1);
        send_noise(16'sh5555);
        send_noise(16'shAAAA);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_ECG_AMPLITUDE, 20'd4095);
        write_reg(CFG_TIME_STEP, 20'd0);
        repeat (3) send_noise(random_noise());
        // Only the low twelve bits reach the amplitude register.
        write_reg(CFG_ECG_AMPLITUDE, 20'hFF000);
        repeat (2) send_noise(random_noise());
        write_reg(CFG_ECG_AMPLITUDE, 20'd4095);
        write_reg(CFG_TIME_STEP, 20'hFFFFF);
        repeat (4) send_noise(random_noise());
        write_reg(CFG_TIME_STEP, 20'd1);
        repeat (2) send_noise(random_noise());
    endtask

    // With a 10 ms step the time lands on every segment bound and on 840 ms
    // exactly once it has wrapped.
    task automatic test_beat_sweep();
        write_reg(CFG_TIME_STEP, 20'd655360);
        repeat (180) send_noise(random_noise());
    endtask

    task automatic test_back_to_back();
        write_reg(CFG_TIME_STEP, 20'd196608);
        write_reg(CFG_ECG_AMPLITUDE, CFG_DATA_W'($urandom_range(4095)));
        no_gaps = 1'b1;
        repeat (120) send_noise(random_noise());
        drain_codes();
        no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_request = 600;
        repeat (8) send_noise(random_noise());
    endtask

    task automatic test_paused_sender();
        repeat (4) begin
            repeat (3) send_noise(random_noise());
            drain_codes();
        end
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] step_word;
        logic [CFG_DATA_W-1:0] amp_word;
        while (noise_sent < 1550) begin
            case ($urandom_range(4))
                0: step_word = CFG_DATA_W'($urandom);
                1: step_word = CFG_DATA_W'($urandom_range(15, 1) << 16);
                2: step_word = CFG_DATA_W'($urandom_range(4095, 1));
                3: step_word = $urandom_range(1) ? 20'hFFFFF : CFG_DATA_W'($urandom_range(1));
                default: step_word = CFG_DATA_W'(65024 + $urandom_range(1023));
            endcase
            amp_word = CFG_DATA_W'($urandom);
            case ($urandom_range(3))
                0: amp_word[AMP_W-1:0] = '0;
                1: amp_word[AMP_W-1:0] = '1;
                default: ;
            endcase
            write_reg(CFG_TIME_STEP, step_word);
            write_reg(CFG_ECG_AMPLITUDE, amp_word);
            repeat ($urandom_range(160, 40)) send_noise(random_noise());
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_noise_extremes();
        test_register_extremes();
        test_beat_sweep();
        test_back_to_back();
        test_output_backpressure();
        test_paused_sender();
        test_random_phases();
        drain_codes();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_codes.size() == 0) begin
            $display("[ecg_waveform_synth_top] OK");
        end else begin
            $display("[ecg_waveform_synth_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ecgws_pkg.sv
hdl/ecgws_sine_rom.sv
hdl/ecgws_serial_mul.sv
hdl/ecgws_serial_div.sv
hdl/ecg_waveform_synth_top.sv
hdl/ecgws_checker.sv
sim/testbench.sv
